### sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int CMD_W        = 2;
	localparam int CHAR_W       = 8;
	localparam int CELL_INDEX_W = 11;
	localparam int ROW_OUT_W    = 5;
	localparam int COL_OUT_W    = 7;
	localparam int CELL_W       = 16;
	localparam int ATTR_W       = 8;

	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
	localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_CLEAR,
		ST_SCROLL,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// what a put request does to the store
	typedef struct packed {
		logic              wr_en;
		logic [CHAR_W-1:0] wr_char;
		logic              scroll;
	} put_act_t;

endpackage

### sv/tcw_req_if.sv
// ----------------------------------------------------------------------------
// tcw_req_if
// request channel of the text console writer
// ----------------------------------------------------------------------------
interface tcw_req_if;
	logic                                valid;
	logic                                ready;
	logic [tcw_pkg::CMD_W-1:0]           command;
	logic [tcw_pkg::CHAR_W-1:0]          char_code;
	logic [tcw_pkg::CELL_INDEX_W-1:0]    cell_index;

	modport source (output valid, command, char_code, cell_index, input ready);
	modport sink   (input valid, command, char_code, cell_index, output ready);
endinterface

### sv/tcw_rsp_if.sv
// ----------------------------------------------------------------------------
// tcw_rsp_if
// result channel of the text console writer
// ----------------------------------------------------------------------------
interface tcw_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [tcw_pkg::ROW_OUT_W-1:0]    cursor_row;
	logic [tcw_pkg::COL_OUT_W-1:0]    cursor_col;
	logic [tcw_pkg::CELL_W-1:0]       cell_data;
	logic                             scrolled;

	modport source (output valid, cursor_row, cursor_col, cell_data, scrolled, input ready);
	modport sink   (input valid, cursor_row, cursor_col, cell_data, scrolled, output ready);
endinterface

### sv/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// text-mode console: cursor plus a ROWS x COLUMNS store of 16-bit cells
// ----------------------------------------------------------------------------
// The cell store is one synchronous memory (one write and one read port, read
// data registered) and every request is served by a small sequencer around it.
// After reset the block walks the whole store once, writing blank cells, and
// takes no request until that pass is done; attribute writes are taken at any
// time. For a put request (character, newline or backspace) any cell write
// happens in the cycle the request is taken; the result is loaded in the emit
// step once the result register is free. A read passes the registered memory
// read and the read step before the emit step. Clear sweeps the store one cell
// a cycle. A put that leaves the bottom row scrolls: the store is copied up one
// row, one cell a cycle through a one-stage read/write pipeline, and the bottom
// row is blanked with the current attribute. The result register is separate
// from the sequencer, so the next request is taken while a result still waits.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                       clk,
	input  logic                       arst_n,
	tcw_req_if.sink                    req,
	tcw_rsp_if.source                  rsp,
	input  logic                       cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);
	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int KEEP  = CELLS - COLUMNS;
	// wide enough for the request index and for the cell count itself
	localparam int IW    = ((AW > CELL_INDEX_W) ? AW : CELL_INDEX_W) + 1;

	// cell store
	logic [CELL_W-1:0] mem [CELLS];
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [CELL_W-1:0] rdata_q;

	// sequencer and cursor
	state_t            state_q, state_d;
	logic [AW-1:0]     ptr_q;
	logic              ptr_last;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ATTR_W-1:0] attr_q;
	logic [CELL_W-1:0] data_q;
	logic              scr_q;
	logic              rd_ok_q;

	// scroll copy pipeline
	logic              vld_s1;
	logic [AW-1:0]     dst_s1;
	logic              keep_s1;

	// result register
	logic                 out_valid_q;
	logic [ROW_OUT_W-1:0] out_row_q;
	logic [COL_OUT_W-1:0] out_col_q;
	logic [CELL_W-1:0]    out_data_q;
	logic                 out_scr_q;

	logic              take;
	logic              emit;
	cmd_t              cmd;
	put_act_t          act;
	logic [ROW_W-1:0]  row_nxt;
	logic [COL_W-1:0]  col_nxt;
	logic [COL_W-1:0]  wr_col;
	logic [AW-1:0]     put_addr;
	logic [IW-1:0]     idx_w;
	logic              idx_ok;
	logic              ptr_keep;

	tcw_cursor #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_cursor (
		.row       (row_q),
		.col       (col_q),
		.char_code (req.char_code),
		.act       (act),
		.row_nxt   (row_nxt),
		.col_nxt   (col_nxt),
		.wr_col    (wr_col)
	);

	assign cmd      = cmd_t'(req.command);
	assign put_addr = AW'(row_q) * AW'(COLUMNS) + AW'(wr_col);
	assign idx_w    = IW'(req.cell_index);
	// indexes past the store read as zero
	assign idx_ok   = (idx_w < IW'(CELLS));
	assign ptr_last = (ptr_q == AW'(CELLS - 1));
	// during a scroll, cells below the kept area take the blank fill
	assign ptr_keep = (ptr_q < AW'(KEEP));
	assign take     = req.valid && req.ready;
	assign emit     = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);

	// next state and memory port control
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = BLANK_CELL;
		mem_raddr = ptr_keep ? ptr_q + AW'(COLUMNS) : ptr_q;
		case (state_q)
			ST_INIT: begin
				// blank pass after reset
				mem_we = 1'b1;
				if (ptr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (cmd)
						CMD_PUT: begin
							mem_we    = act.wr_en;
							mem_waddr = put_addr;
							mem_wdata = {attr_q, act.wr_char};
							state_d   = act.scroll ? ST_SCROLL : ST_EMIT;
						end
						CMD_CLEAR: begin
							state_d = ST_CLEAR;
						end
						CMD_READ: begin
							mem_raddr = idx_w[AW-1:0];
							state_d   = ST_READ;
						end
						default: begin
							state_d = ST_EMIT;
						end
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (ptr_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_SCROLL, ST_DRAIN: begin
				// write back the cell read in the previous cycle, or a blank
				mem_we    = vld_s1;
				mem_waddr = dst_s1;
				mem_wdata = keep_s1 ? rdata_q : {attr_q, CH_SPACE};
				if (state_q == ST_DRAIN) begin
					state_d = ST_EMIT;
				end else if (ptr_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// sweep pointer, cursor and attribute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			attr_q  <= ATTR_RESET;
			vld_s1  <= 1'b0;
			scr_q   <= 1'b0;
			rd_ok_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (state_q == ST_INIT || state_q == ST_CLEAR || state_q == ST_SCROLL) begin
				ptr_q <= ptr_last ? '0 : ptr_q + AW'(1);
			end
			vld_s1 <= (state_q == ST_SCROLL);
			if (take) begin
				rd_ok_q <= idx_ok;
				// only a put can scroll
				scr_q   <= (cmd == CMD_PUT) && act.scroll;
				case (cmd)
					CMD_PUT: begin
						row_q <= row_nxt;
						col_q <= col_nxt;
					end
					CMD_CLEAR: begin
						row_q <= '0;
						col_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// payload of the pipeline and the pending result
	always_ff @(posedge clk) begin
		dst_s1  <= ptr_q;
		keep_s1 <= ptr_keep;
		if (take) begin
			data_q <= '0;
		end else if (state_q == ST_READ) begin
			data_q <= rd_ok_q ? rdata_q : '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row_q  <= ROW_OUT_W'(row_q);
			out_col_q  <= COL_OUT_W'(col_q);
			out_data_q <= data_q;
			out_scr_q  <= scr_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.cursor_row = out_row_q;
	assign rsp.cursor_col = out_col_q;
	assign rsp.cell_data  = out_data_q;
	assign rsp.scrolled   = out_scr_q;

`ifndef NO_ASSERTIONS
	// cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(row_q) < ROWS) && (32'(col_q) < COLUMNS))
		else $error("cursor off screen");

	// no write lands outside the store
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (32'(mem_waddr) < CELLS))
		else $error("store write out of range");

	// a result is only loaded from the emit step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result without emit step");

	// a scrolled result reports the bottom row
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_scr_q) |-> (out_row_q == ROW_OUT_W'(ROWS - 1)))
		else $error("scroll result not on bottom row");
`endif

endmodule

### sv/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor
// cursor step for a put request: newline, backspace and ordinary characters
// ----------------------------------------------------------------------------
module tcw_cursor #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic [$clog2(ROWS)-1:0]         row,
	input  logic [$clog2(COLUMNS)-1:0]      col,
	input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
	output tcw_pkg::put_act_t               act,
	output logic [$clog2(ROWS)-1:0]         row_nxt,
	output logic [$clog2(COLUMNS)-1:0]      col_nxt,
	output logic [$clog2(COLUMNS)-1:0]      wr_col
);
	import tcw_pkg::*;

	localparam int ROW_W = $clog2(ROWS);
	localparam int COL_W = $clog2(COLUMNS);

	logic             row_last;
	logic [ROW_W-1:0] row_adv;

	// next row, staying on the bottom row when the screen scrolls
	assign row_last = (row == ROW_W'(ROWS - 1));
	assign row_adv  = row_last ? row : row + ROW_W'(1);

	always_comb begin
		act.wr_en   = 1'b0;
		act.wr_char = char_code;
		act.scroll  = 1'b0;
		row_nxt     = row;
		col_nxt     = col;
		wr_col      = col;
		if (char_code == CH_NEWLINE) begin
			col_nxt    = '0;
			row_nxt    = row_adv;
			act.scroll = row_last;
		end else if (char_code == CH_BACKSPACE) begin
			if (col != '0) begin
				col_nxt     = col - COL_W'(1);
				wr_col      = col - COL_W'(1);
				act.wr_en   = 1'b1;
				act.wr_char = CH_SPACE;
			end
		end else begin
			act.wr_en = 1'b1;
			if (col == COL_W'(COLUMNS - 1)) begin
				col_nxt    = '0;
				row_nxt    = row_adv;
				act.scroll = row_last;
			end else begin
				col_nxt = col + COL_W'(1);
			end
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// request/result check of the text console writer against a cycle-free model
// of the console kept in the bench: cursor, cell store and attribute register
// ----------------------------------------------------------------------------
// a short table of directed requests runs first, most rows with their result
// typed in, then random requests in six segments: three idle mixes, two
// attribute settings per mix. every accepted request updates the console model
// and queues the result it should give; every accepted result is compared
// with the oldest queued one.
// ----------------------------------------------------------------------------
module testbench;
	import tcw_pkg::*;

	localparam int COLS       = 80;
	localparam int ROWS_N     = 25;
	localparam int CELL_COUNT = COLS * ROWS_N;
	localparam int RANDOM_ITEMS = 1700;
	localparam int SEGMENTS     = 6;
	// quiet cycles between the last result and an attribute write
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] col;
		logic [CELL_W-1:0]    data;
		logic                 scrolled;
	} console_result_t;

	// one row of the directed table: either an attribute write (value in
	// data8) or a request repeated reps times, with an optional typed result
	typedef struct packed {
		bit                      is_cfg;
		cmd_t                    cmd;
		logic [CHAR_W-1:0]       data8;
		logic [CELL_INDEX_W-1:0] idx;
		int                      reps;
		bit                      typed;
		console_result_t         want;
	} directed_step_t;

	localparam int DIRECTED_ROWS = 33;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ATTR_W-1:0] cfg_wdata;

	tcw_req_if req_bus ();
	tcw_rsp_if rsp_bus ();

	text_console_writer_core #(
		.COLUMNS (COLS),
		.ROWS    (ROWS_N)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_bus.sink),
		.rsp       (rsp_bus.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// console model state
	logic [CELL_W-1:0] screen_cells [CELL_COUNT];
	int                cur_row;
	int                cur_col;
	logic [ATTR_W-1:0] text_attr;

	console_result_t pending_results [$];
	console_result_t oldest;
	int              mismatch_count;

	// idle percentages of sender and receiver, changed between segments
	int send_idle_pct;
	int take_idle_pct;

	directed_step_t directed_steps [DIRECTED_ROWS] = '{
		// fresh after reset: blank store, cursor home
		'{0, CMD_READ,  8'h00, 11'd0,    1, 1, '{5'd0,  7'd0, 16'h0720, 1'b0}},
		'{0, CMD_READ,  8'h00, 11'd1999, 1, 1, '{5'd0,  7'd0, 16'h0720, 1'b0}},
		// reads past the end of the store give zero
		'{0, CMD_READ,  8'h00, 11'd2000, 1, 1, '{5'd0,  7'd0, 16'h0000, 1'b0}},
		'{0, CMD_READ,  8'h00, 11'h7FF,  1, 1, '{5'd0,  7'd0, 16'h0000, 1'b0}},
		// spare command code does nothing
		'{0, CMD_NOP,   8'hFF, 11'h7FF,  1, 1, '{5'd0,  7'd0, 16'h0000, 1'b0}},
		// character extremes
		'{0, CMD_PUT,   8'h41, 11'd0,    1, 1, '{5'd0,  7'd1, 16'h0000, 1'b0}},
		'{0, CMD_PUT,   8'hFF, 11'd0,    1, 1, '{5'd0,  7'd2, 16'h0000, 1'b0}},
		'{0, CMD_PUT,   8'h00, 11'd0,    1, 1, '{5'd0,  7'd3, 16'h0000, 1'b0}},
		'{0, CMD_READ,  8'h00, 11'd0,    1, 1, '{5'd0,  7'd3, 16'h0741, 1'b0}},
		'{0, CMD_READ,  8'h00, 11'd1,    1, 1, '{5'd0,  7'd3, 16'h07FF, 1'b0}},
		'{0, CMD_READ,  8'h00, 11'd2,    1, 1, '{5'd0,  7'd3, 16'h0700, 1'b0}},
		// backspace blanks the cell it steps onto
		'{0, CMD_PUT,   8'h08, 11'd0,    1, 1, '{5'd0,  7'd2, 16'h0000, 1'b0}},
		'{0, CMD_READ,  8'h00, 11'd2,    1, 1, '{5'd0,  7'd2, 16'h0720, 1'b0}},
		'{0, CMD_PUT,   8'h0A, 11'd0,    1, 1, '{5'd1,  7'd0, 16'h0000, 1'b0}},
		// backspace at the left margin is ignored
		'{0, CMD_PUT,   8'h08, 11'd0,    1, 1, '{5'd1,  7'd0, 16'h0000, 1'b0}},
		'{1, CMD_NOP,   8'hFF, 11'd0,    1, 0, '0},
		'{0, CMD_PUT,   8'h5A, 11'd0,    1, 1, '{5'd1,  7'd1, 16'h0000, 1'b0}},
		'{0, CMD_READ,  8'h00, 11'd80,   1, 1, '{5'd1,  7'd1, 16'hFF5A, 1'b0}},
		'{1, CMD_NOP,   8'h00, 11'd0,    1, 0, '0},
		'{0, CMD_PUT,   8'h08, 11'd0,    1, 1, '{5'd1,  7'd0, 16'h0000, 1'b0}},
		'{0, CMD_READ,  8'h00, 11'd80,   1, 1, '{5'd1,  7'd0, 16'h0020, 1'b0}},
		// walk down to the bottom row and fill it up to the last column
		'{0, CMD_PUT,   8'h0A, 11'd0,   23, 0, '0},
		'{0, CMD_PUT,   8'h7E, 11'd0,   79, 0, '0},
		// wrap off the last column of the bottom row scrolls
		'{0, CMD_PUT,   8'h30, 11'd0,    1, 1, '{5'd24, 7'd0, 16'h0000, 1'b1}},
		'{0, CMD_READ,  8'h00, 11'd1999, 1, 1, '{5'd24, 7'd0, 16'h0020, 1'b0}},
		'{0, CMD_READ,  8'h00, 11'd1840, 1, 1, '{5'd24, 7'd0, 16'h007E, 1'b0}},
		// newline on the bottom row scrolls, blank row takes the new attribute
		'{1, CMD_NOP,   8'hA5, 11'd0,    1, 0, '0},
		'{0, CMD_PUT,   8'h0A, 11'd0,    1, 1, '{5'd24, 7'd0, 16'h0000, 1'b1}},
		'{0, CMD_READ,  8'h00, 11'd1999, 1, 1, '{5'd24, 7'd0, 16'hA520, 1'b0}},
		'{0, CMD_READ,  8'h00, 11'd1760, 1, 1, '{5'd24, 7'd0, 16'h007E, 1'b0}},
		// clear ignores the attribute register
		'{0, CMD_CLEAR, 8'h00, 11'd0,    1, 1, '{5'd0,  7'd0, 16'h0000, 1'b0}},
		'{0, CMD_READ,  8'h00, 11'd1999, 1, 1, '{5'd0,  7'd0, 16'h0720, 1'b0}},
		'{0, CMD_READ,  8'h00, 11'd0,    1, 1, '{5'd0,  7'd0, 16'h0720, 1'b0}}
	};

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model

	// move to the next row, scrolling the store up when leaving the bottom
	task automatic row_advance(output logic scrolled);
		int i;
		scrolled = 1'b0;
		cur_row++;
		if (cur_row >= ROWS_N) begin
			for (i = 0; i < CELL_COUNT - COLS; i++)
				screen_cells[i] = screen_cells[i + COLS];
			for (i = CELL_COUNT - COLS; i < CELL_COUNT; i++)
				screen_cells[i] = {text_attr, CH_SPACE};
			cur_row  = ROWS_N - 1;
			scrolled = 1'b1;
		end
	endtask

	// apply one request to the console model and give its result
	task automatic advance_console(input cmd_t c, input logic [CHAR_W-1:0] ch,
			input logic [CELL_INDEX_W-1:0] idx, output console_result_t r);
		int i;
		logic scr;
		r   = '0;
		scr = 1'b0;
		case (c)
			CMD_PUT: begin
				if (ch == CH_NEWLINE) begin
					cur_col = 0;
					row_advance(scr);
				end else if (ch == CH_BACKSPACE) begin
					// nothing happens at column 0
					if (cur_col > 0) begin
						cur_col--;
						screen_cells[cur_row * COLS + cur_col] = {text_attr, CH_SPACE};
					end
				end else begin
					screen_cells[cur_row * COLS + cur_col] = {text_attr, ch};
					cur_col++;
					if (cur_col >= COLS) begin
						cur_col = 0;
						row_advance(scr);
					end
				end
			end
			CMD_CLEAR: begin
				for (i = 0; i < CELL_COUNT; i++)
					screen_cells[i] = BLANK_CELL;
				cur_row = 0;
				cur_col = 0;
			end
			CMD_READ: begin
				if (idx < CELL_COUNT)
					r.data = screen_cells[idx];
			end
			default: ;
		endcase
		r.row      = cur_row[ROW_OUT_W-1:0];
		r.col      = cur_col[COL_OUT_W-1:0];
		r.scrolled = scr;
	endtask

	// ------------------------------------------------------------- sender

	// present one request from the next falling edge on, with random gaps
	// in front of it, and return at the rising edge that takes it
	task automatic issue_request(input cmd_t c, input logic [CHAR_W-1:0] ch,
			input logic [CELL_INDEX_W-1:0] idx, input bit use_typed,
			input console_result_t typed_r);
		console_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid      <= 1'b1;
		req_bus.command    <= c;
		req_bus.char_code  <= ch;
		req_bus.cell_index <= idx;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		advance_console(c, ch, idx, r);
		pending_results.push_back(use_typed ? typed_r : r);
	endtask

	// drop valid, let every queued result come back, then let the block settle
	task automatic wait_drained();
		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_attribute(input logic [ATTR_W-1:0] a);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		text_attr = a;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one random request: mostly text, with newlines and backspaces to move
	// the cursor around, reads (a third aimed near the cursor), rare clears and spare commands
	task automatic random_request();
		int pick;
		int pos;
		cmd_t c;
		logic [CHAR_W-1:0] ch;
		logic [CELL_INDEX_W-1:0] idx;
		pick = $urandom_range(999);
		c    = CMD_PUT;
		ch   = CHAR_W'($urandom_range(255));
		idx  = CELL_INDEX_W'($urandom_range(2047));
		if (pick < 620) begin
			c = CMD_PUT;
		end else if (pick < 700) begin
			ch = CH_NEWLINE;
		end else if (pick < 770) begin
			ch = CH_BACKSPACE;
		end else if (pick < 970) begin
			c = CMD_READ;
			case ($urandom_range(2))
				0: begin
					// just behind the cursor, where the latest writes landed
					pos = cur_row * COLS + cur_col - int'($urandom_range(4));
					idx = (pos < 0) ? '0 : CELL_INDEX_W'(pos);
				end
				1: idx = CELL_INDEX_W'($urandom_range(CELL_COUNT - 1));
				default: ;
			endcase
		end else if (pick < 974) begin
			c = CMD_CLEAR;
		end else begin
			c = CMD_NOP;
		end
		issue_request(c, ch, idx, 1'b0, '0);
	endtask

	// ------------------------------------------------------------ receiver

	always @(negedge clk)
		rsp_bus.ready <= ($urandom_range(99) >= take_idle_pct);

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// compare every accepted result with the oldest outstanding one
	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				mismatch_count++;
			end else begin
				oldest = pending_results.pop_front();
				check_field("cursor_row", int'(oldest.row), int'(rsp_bus.cursor_row));
				check_field("cursor_col", int'(oldest.col), int'(rsp_bus.cursor_col));
				check_field("cell_data",  int'(oldest.data), int'(rsp_bus.cell_data));
				check_field("scrolled",   int'(oldest.scrolled), int'(rsp_bus.scrolled));
			end
		end
	end

	// ----------------------------------------------------------- sequence

	initial begin : stimulus
		int row;
		int k;
		int seg;
		logic [ATTR_W-1:0] seg_attr [SEGMENTS];
		// all inputs known from time zero
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		req_bus.valid      = 1'b0;
		req_bus.command    = CMD_NOP;
		req_bus.char_code  = '0;
		req_bus.cell_index = '0;
		rsp_bus.ready      = 1'b0;
		mismatch_count     = 0;
		send_idle_pct      = 22;
		take_idle_pct      = 85;
		// model starts where reset leaves the block
		for (k = 0; k < CELL_COUNT; k++)
			screen_cells[k] = BLANK_CELL;
		cur_row   = 0;
		cur_col   = 0;
		text_attr = ATTR_RESET;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table; the block is still blanking its store, the first
		// request simply waits for ready
		for (row = 0; row < DIRECTED_ROWS; row++) begin
			if (directed_steps[row].is_cfg) begin
				wait_drained();
				write_attribute(directed_steps[row].data8);
			end else begin
				for (k = 0; k < directed_steps[row].reps; k++)
					issue_request(directed_steps[row].cmd, directed_steps[row].data8,
						directed_steps[row].idx, directed_steps[row].typed,
						directed_steps[row].want);
			end
		end

		// random part: attribute extremes and random values across the mixes
		seg_attr[0] = 8'hFF;
		seg_attr[1] = ATTR_W'($urandom_range(255));
		seg_attr[2] = 8'h00;
		seg_attr[3] = ATTR_W'($urandom_range(255));
		seg_attr[4] = ATTR_W'($urandom_range(255));
		seg_attr[5] = ATTR_RESET;
		for (seg = 0; seg < SEGMENTS; seg++) begin
			wait_drained();
			case (seg / 2)
				0: begin
					send_idle_pct = 22;
					take_idle_pct = 85;
				end
				1: begin
					send_idle_pct = 85;
					take_idle_pct = 22;
				end
				default: begin
					send_idle_pct = 0;
					take_idle_pct = 0;
				end
			endcase
			write_attribute(seg_attr[seg]);
			repeat (RANDOM_ITEMS / SEGMENTS) random_request();
		end

		wait_drained();
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// hang guard: even if every request scrolled and waited on a slow receiver,
	// the run stays well inside this
	initial begin : watchdog
		#40_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
